FILE: src/mtl_pkg.sv
// ----------------------------------------------------------------------------
// mtl_pkg
// shared types and constants for the mac learning table
// ----------------------------------------------------------------------------
`default_nettype none

package mtl_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic ACT_LEARN = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  typedef enum logic [2:0] {
    ST_NEW     = 3'd0,
    ST_REFRESH = 3'd1,
    ST_MOVE    = 3'd2,
    ST_FULL    = 3'd3,
    ST_FLUSH   = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [47:0] mac_addr;
    logic [11:0] vlan_id;
    logic [3:0]  port_num;
    logic        is_static;
  } mtl_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] previous_port;
    logic [7:0] removed_count;
    logic [7:0] occupancy;
  } mtl_out_t;

  // token walking down the cell chain, one cell per cycle
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [3:0]       prev_port;
    logic [CNT_W-1:0] removed;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } mtl_tok_t;

  // insert command broadcast to all cells
  typedef struct packed {
    logic             go;
    logic [IDX_W-1:0] idx;
  } mtl_ins_t;

endpackage

`default_nettype wire

FILE: src/mtl_cell.sv
// ----------------------------------------------------------------------------
// mtl_cell
// one table slot; updates itself as the search token passes and hands it on
// ----------------------------------------------------------------------------
`default_nettype none

module mtl_cell (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire  [mtl_pkg::IDX_W-1:0]      cell_idx,
  input  wire  mtl_pkg::mtl_in_t         req,
  input  wire  mtl_pkg::mtl_ins_t        ins,
  input  wire  mtl_pkg::mtl_tok_t        tok_in,
  output mtl_pkg::mtl_tok_t              tok_out
);
  import mtl_pkg::*;

  logic        valid_r, valid_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [11:0] vlan_r, vlan_nxt;
  logic [3:0]  port_r, port_nxt;
  logic        static_r, static_nxt;
  mtl_tok_t    tok_r, tok_nxt;
  logic        key_hit;

  assign key_hit = valid_r && (mac_r == req.mac_addr) && (vlan_r == req.vlan_id);

  always_comb begin
    valid_nxt  = valid_r;
    mac_nxt    = mac_r;
    vlan_nxt   = vlan_r;
    port_nxt   = port_r;
    static_nxt = static_r;
    tok_nxt    = tok_in;
    if (tok_in.vld) begin
      if (req.action == ACT_FLUSH) begin
        if (valid_r && (port_r == req.port_num) && !static_r) begin
          valid_nxt       = 1'b0;
          tok_nxt.removed = CNT_W'(tok_in.removed + 1'b1);
        end
      end else begin
        if (key_hit) begin
          // move or refresh; type is kept
          tok_nxt.found     = 1'b1;
          tok_nxt.prev_port = port_r;
          port_nxt          = req.port_num;
        end
        if (!valid_r && !tok_in.free_found) begin
          tok_nxt.free_found = 1'b1;
          tok_nxt.free_idx   = cell_idx;
        end
      end
    end
    if (ins.go && (ins.idx == cell_idx)) begin
      valid_nxt  = 1'b1;
      mac_nxt    = req.mac_addr;
      vlan_nxt   = req.vlan_id;
      port_nxt   = req.port_num;
      static_nxt = req.is_static;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // only the token valid bit needs a reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
    tok_r.found      <= tok_nxt.found;
    tok_r.prev_port  <= tok_nxt.prev_port;
    tok_r.removed    <= tok_nxt.removed;
    tok_r.free_found <= tok_nxt.free_found;
    tok_r.free_idx   <= tok_nxt.free_idx;
  end

  always_ff @(posedge clk) begin
    mac_r    <= mac_nxt;
    vlan_r   <= vlan_nxt;
    port_r   <= port_nxt;
    static_r <= static_nxt;
  end

  assign tok_out = tok_r;

endmodule

`default_nettype wire

FILE: src/mac_learning_table_top.sv
// ----------------------------------------------------------------------------
// mac_learning_table_top
// fully associative mac/vlan learning table built as a chain of slot cells
// ----------------------------------------------------------------------------
// usage
//   a request is taken at a rising edge with start high and busy low; it is
//   either a learn (search mac_addr/vlan_id, then refresh, move, add or drop
//   as table full) or a flush (drop every dynamic entry on port_num)
//   exactly one result per request shows on out_res for one cycle, marked by
//   out_valid; the receiver cannot stall, so nothing waits on it
// request walk
//   a search token walks the chain of TABLE_DEPTH cells, one cell per cycle;
//   after the accepting edge launch_r, each cell's token register and then
//   out_valid_r are registered in turn, and the result is taken at the edge
//   after that; busy falls in the same cycle as out_valid rises, so a new
//   request is only taken once the previous one has finished its walk
//   the walk through the cell chain sets how often requests can be taken
// reset
//   synchronous active-low rst_n clears all slot valid bits, the occupancy
//   count and any request in flight; slot contents are left as they are
// ----------------------------------------------------------------------------
`default_nettype none

module mac_learning_table_top (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               start,
  output logic              busy,
  input  wire  mtl_pkg::mtl_in_t in_req,
  output logic              out_valid,
  output mtl_pkg::mtl_out_t out_res
);
  import mtl_pkg::*;

  // request held for the whole walk, broadcast to every cell
  mtl_in_t          req_r, req_nxt;
  logic             busy_r, busy_nxt;
  logic             launch_r, launch_nxt;
  logic             out_valid_r, out_valid_nxt;
  mtl_out_t         out_r, out_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  // token chain: tok[i] feeds cell i, tok[TABLE_DEPTH] comes off the end
  mtl_tok_t               tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH:0]   tok_vlds;
  mtl_tok_t               tok_head;
  mtl_tok_t               tok_end;
  mtl_ins_t               ins;
  logic                   accept;
  logic                   fin;

  assign accept = start && !busy_r;
  assign tok_end = tok[TABLE_DEPTH];
  assign fin     = tok_end.vld;

  // fresh token enters the head of the chain in the cycle after accept
  always_comb begin
    tok_head     = '0;
    tok_head.vld = launch_r;
  end

  assign tok[0] = tok_head;

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      mtl_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(gi)),
        .req      (req_r),
        .ins      (ins),
        .tok_in   (tok[gi]),
        .tok_out  (tok[gi+1])
      );
    end
    for (gi = 0; gi <= TABLE_DEPTH; gi++) begin : g_vld
      assign tok_vlds[gi] = tok[gi].vld;
    end
  endgenerate

  // accept a request; on finish build the result and, on a miss with room, write the free slot
  always_comb begin
    req_nxt       = req_r;
    busy_nxt      = busy_r;
    launch_nxt    = 1'b0;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    count_nxt     = count_r;
    ins.go        = 1'b0;
    ins.idx       = tok_end.free_idx;

    if (accept) begin
      req_nxt    = in_req;
      busy_nxt   = 1'b1;
      launch_nxt = 1'b1;
    end

    if (fin) begin
      busy_nxt              = 1'b0;
      out_valid_nxt         = 1'b1;
      out_nxt.previous_port = req_r.port_num;
      out_nxt.removed_count = 8'd0;
      if (req_r.action == ACT_FLUSH) begin
        count_nxt             = CNT_W'(count_r - tok_end.removed);
        out_nxt.status        = ST_FLUSH;
        out_nxt.removed_count = 8'(tok_end.removed);
      end else if (tok_end.found) begin
        if (tok_end.prev_port != req_r.port_num) begin
          out_nxt.status        = ST_MOVE;
          out_nxt.previous_port = tok_end.prev_port;
        end else begin
          out_nxt.status = ST_REFRESH;
        end
      end else if (tok_end.free_found) begin
        ins.go         = 1'b1;
        count_nxt      = CNT_W'(count_r + 1'b1);
        out_nxt.status = ST_NEW;
      end else begin
        out_nxt.status = ST_FULL;
      end
      out_nxt.occupancy = 8'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r <= req_nxt;
    out_r <= out_nxt;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef NO_ASSERTIONS
  // only one request may be walking the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vlds))
    else $error("more than one search token in flight");

  // a result is only issued as the request completes
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy_r)
    else $error("result strobe while still busy");

  // an accepted request launches a token next cycle
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (launch_r && busy_r))
    else $error("accepted request did not launch");

  // occupancy never exceeds the table size
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("occupancy above table depth");

  // token is only in the chain while busy
  a_busy_tok: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vlds != '0) |-> busy_r)
    else $error("token in chain while idle");
`endif

endmodule

`default_nettype wire

FILE: tb/mac_learning_table_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_learning_table_top_tb
// self-checking bench for the mac/vlan learning table
// ----------------------------------------------------------------------------
// every accepted request runs through a local model of the slot table, and the
// predicted result is queued; each out_valid pulse is checked field by field
// against the oldest queued result. directed requests cover key extremes,
// refresh, move, flush and table full, then keyed random traffic runs under
// several sender idle profiles
// ----------------------------------------------------------------------------

module mac_learning_table_top_tb;
  import mtl_pkg::*;

  localparam int     CLK_HALF     = 4;
  localparam int     RESET_CYCLES = 5;
  // one request walks the whole cell chain before the next is taken
  localparam int     LATENCY      = TABLE_DEPTH + 2;
  localparam int     MAX_GAP      = 200;
  // worst case is roughly 1700 requests, each with a full walk and a sender
  // gap of up to MAX_GAP, taken several times over
  localparam longint CYCLE_LIMIT  = 2_500_000;
  localparam int     KEY_POOL     = 40;
  localparam int     MAX_REPORTS  = 10;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  logic     busy;
  mtl_in_t  in_req  = '0;
  logic     out_valid;
  mtl_out_t out_res;

  // local copy of the slot table, updated as each request is accepted
  logic        tbl_valid  [TABLE_DEPTH];
  logic [47:0] tbl_mac    [TABLE_DEPTH];
  logic [11:0] tbl_vlan   [TABLE_DEPTH];
  logic [3:0]  tbl_port   [TABLE_DEPTH];
  logic        tbl_static [TABLE_DEPTH];
  int unsigned tbl_count;

  // results still owed by the dut, oldest first
  mtl_out_t pending_results[$];

  // keys that random traffic keeps coming back to, so refreshes and moves
  // happen often; odd entries share the mac of the even one before them
  logic [47:0] key_mac  [KEY_POOL];
  logic [11:0] key_vlan [KEY_POOL];
  logic [3:0]  key_port [KEY_POOL];

  int     idle_pct;
  int     mismatches;
  int     requests_sent;
  int     learns_sent;
  int     flushes_sent;
  int     status_seen [5];
  longint cycle_count;

  mac_learning_table_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // watchdog: a hang or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // table model: applies one request and returns the result it must produce
  // ---------------------------------------------------------------------------
  function automatic mtl_out_t predict_table_update(input mtl_in_t req);
    mtl_out_t    res;
    int unsigned removed;
    int          hit_idx;
    int          free_idx;
    removed  = 0;
    hit_idx  = -1;
    free_idx = -1;
    res.previous_port = req.port_num;
    res.removed_count = '0;
    if (req.action == ACT_FLUSH) begin
      // static entries survive a flush, key fields play no part
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (tbl_valid[i] && tbl_port[i] == req.port_num && !tbl_static[i]) begin
          tbl_valid[i] = 1'b0;
          removed++;
        end
      end
      tbl_count        -= removed;
      res.status        = ST_FLUSH;
      res.removed_count = removed[7:0];
    end else begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        if (hit_idx < 0 && tbl_valid[i] && tbl_mac[i] == req.mac_addr &&
            tbl_vlan[i] == req.vlan_id)
          hit_idx = i;
        if (free_idx < 0 && !tbl_valid[i])
          free_idx = i;
      end
      if (hit_idx >= 0) begin
        // a move keeps the entry type, is_static is not looked at
        if (tbl_port[hit_idx] != req.port_num) begin
          res.status            = ST_MOVE;
          res.previous_port     = tbl_port[hit_idx];
          tbl_port[hit_idx]     = req.port_num;
        end else begin
          res.status = ST_REFRESH;
        end
      end else if (free_idx >= 0) begin
        tbl_valid[free_idx]  = 1'b1;
        tbl_mac[free_idx]    = req.mac_addr;
        tbl_vlan[free_idx]   = req.vlan_id;
        tbl_port[free_idx]   = req.port_num;
        tbl_static[free_idx] = req.is_static;
        tbl_count++;
        res.status = ST_NEW;
      end else begin
        res.status = ST_FULL;
      end
    end
    res.occupancy = tbl_count[7:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: one compare per out_valid pulse against the oldest entry
  // ---------------------------------------------------------------------------
  task automatic log_mismatch(input string what, input mtl_out_t want,
                              input mtl_out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("[%0t] mismatch (%s): expected st %0d prev %0d rem %0d occ %0d,%s",
               $realtime, what, want.status, want.previous_port,
               want.removed_count, want.occupancy,
               $sformatf(" got st %0d prev %0d rem %0d occ %0d", got.status,
                         got.previous_port, got.removed_count, got.occupancy));
  endtask

  always @(posedge clk) begin
    mtl_out_t want;
    string    bad;
    if (rst_n && out_valid) begin
      if (out_res.status <= ST_FLUSH)
        status_seen[out_res.status]++;
      if (pending_results.size() == 0) begin
        log_mismatch("no request pending", '0, out_res);
      end else begin
        want = pending_results.pop_front();
        bad  = "";
        if (out_res.status !== want.status)               bad = {bad, " status"};
        if (out_res.previous_port !== want.previous_port) bad = {bad, " previous_port"};
        if (out_res.removed_count !== want.removed_count) bad = {bad, " removed_count"};
        if (out_res.occupancy !== want.occupancy)         bad = {bad, " occupancy"};
        if (bad != "")
          log_mismatch({"field", bad}, want, out_res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  // start may be raised while busy is still high, so the gap can land on any
  // point of the previous walk; the request is taken at the first edge with
  // busy low
  task automatic send_request(input mtl_in_t req);
    @(negedge clk);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_table_update(req));
    requests_sent++;
    if (req.action == ACT_FLUSH) flushes_sent++;
    else                         learns_sent++;
  endtask

  // hold off new requests until every owed result is back
  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic mtl_in_t make_req(input logic act, input logic [47:0] mac,
                                       input logic [11:0] vlan,
                                       input logic [3:0] port, input logic stat);
    mtl_in_t req;
    req.action    = act;
    req.mac_addr  = mac;
    req.vlan_id   = vlan;
    req.port_num  = port;
    req.is_static = stat;
    return req;
  endfunction

  function automatic logic [47:0] rand_mac();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // mostly learns on pooled keys (refresh or move), some fresh keys, some
  // flushes carrying junk in the key fields
  function automatic mtl_in_t next_random_request();
    mtl_in_t req;
    int      pick;
    int      k;
    pick = $urandom_range(99);
    req  = make_req(ACT_LEARN, rand_mac(), 12'($urandom), 4'($urandom),
                    $urandom_range(19) == 0);
    if (pick < 10) begin
      req.action    = ACT_FLUSH;
      req.is_static = 1'($urandom);
    end else if (pick < 75) begin
      k = $urandom_range(KEY_POOL - 1);
      req.mac_addr  = key_mac[k];
      req.vlan_id   = key_vlan[k];
      req.is_static = $urandom_range(3) == 0;
      if ($urandom_range(1) == 0)
        req.port_num = key_port[k];
      key_port[k] = req.port_num;
    end
    return req;
  endfunction

  task automatic run_random_traffic(input int count);
    repeat (count) send_request(next_random_request());
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_reset();
    for (int i = 0; i < TABLE_DEPTH; i++) tbl_valid[i] = 1'b0;
    tbl_count = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
  endtask

  // key extremes, refresh, move keeping type, flush keeping statics
  task automatic test_directed();
    idle_pct = 0;
    // empty flush, junk in the ignored fields
    send_request(make_req(ACT_FLUSH, '1, '1, 4'h0, 1'b1));
    send_request(make_req(ACT_LEARN, '0, '0, 4'h0, 1'b0));
    send_request(make_req(ACT_LEARN, '1, '1, 4'hf, 1'b1));
    send_request(make_req(ACT_LEARN, '0, '0, 4'h0, 1'b1));   // refresh
    send_request(make_req(ACT_LEARN, '0, '1, 4'h0, 1'b0));   // same mac, other vlan
    send_request(make_req(ACT_LEARN, '1, '0, 4'h5, 1'b0));   // same vlan, other mac
    send_request(make_req(ACT_LEARN, '1, '1, 4'h3, 1'b0));   // move, stays static
    send_request(make_req(ACT_LEARN, '0, '0, 4'h9, 1'b1));   // move, stays dynamic
    send_request(make_req(ACT_FLUSH, '0, '0, 4'h3, 1'b0));   // static survives
    send_request(make_req(ACT_FLUSH, '0, '0, 4'h9, 1'b0));
    send_request(make_req(ACT_LEARN, '0, '0, 4'h9, 1'b0));   // back as new
    send_request(make_req(ACT_LEARN, 48'h0123_4567_89ab, 12'h5a5, 4'ha, 1'b0));
    send_request(make_req(ACT_LEARN, 48'hfedc_ba98_7654, 12'ha5a, 4'ha, 1'b0));
    send_request(make_req(ACT_FLUSH, 48'h8000_0000_0001, 12'h801, 4'ha, 1'b1));
    send_request(make_req(ACT_FLUSH, '0, '0, 4'h0, 1'b0));
    send_request(make_req(ACT_FLUSH, '0, '0, 4'hf, 1'b0));
    send_request(make_req(ACT_LEARN, '1, '1, 4'h3, 1'b0));   // refresh of a static
  endtask

  task automatic test_key_pool_setup();
    for (int i = 0; i < KEY_POOL; i++) begin
      key_mac[i]  = (i % 2 == 0) ? rand_mac() : key_mac[i - 1];
      key_vlan[i] = (i % 2 == 0) ? 12'($urandom)
                                 : key_vlan[i - 1] ^ 12'($urandom_range(4095, 1));
      key_port[i] = 4'($urandom);
    end
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_random_traffic(500);
  endtask

  task automatic test_sender_idle();
    idle_pct = 65;
    run_random_traffic(500);
  endtask

  // a full hold-off halfway through light idling
  task automatic test_drain_pause();
    idle_pct = 7;
    run_random_traffic(250);
    wait_for_drain();
    run_random_traffic(250);
  endtask

  // fill every free slot with dynamic entries, hit the full case, then empty the
  // dynamic part of the table port by port
  task automatic test_table_full();
    idle_pct = 7;
    while (tbl_count < TABLE_DEPTH)
      send_request(make_req(ACT_LEARN, rand_mac(), 12'($urandom), 4'($urandom),
                            1'b0));
    send_request(make_req(ACT_LEARN, rand_mac(), 12'($urandom), 4'($urandom), 1'b0));
    send_request(make_req(ACT_LEARN, rand_mac(), 12'($urandom), 4'($urandom), 1'b1));
    // a known key still moves and refreshes with no free slot
    send_request(make_req(ACT_LEARN, '1, '1, 4'h7, 1'b0));
    send_request(make_req(ACT_LEARN, '1, '1, 4'h7, 1'b0));
    for (int p = 0; p < 16; p++)
      send_request(make_req(ACT_FLUSH, rand_mac(), 12'($urandom), 4'(p), 1'($urandom)));
  endtask

  initial begin
    test_reset();
    test_directed();
    test_key_pool_setup();
    test_back_to_back();
    test_sender_idle();
    test_drain_pause();
    test_table_full();

    // let the last walk finish and make sure nothing stray follows it
    wait_for_drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (pending_results.size() != 0) mismatches++;

    $display("%0d requests (%0d learns, %0d flushes) over %0d cycles",
             requests_sent, learns_sent, flushes_sent, cycle_count);
    $display("results: new %0d, refresh %0d, move %0d, table full %0d, flush %0d",
             status_seen[ST_NEW], status_seen[ST_REFRESH], status_seen[ST_MOVE],
             status_seen[ST_FULL], status_seen[ST_FLUSH]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
